>>> rtl/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int QUEUE_DEPTH   = 16;
	localparam int ID_BITS       = 8;
	localparam int PRI_BITS      = 32;
	localparam int CNT_BITS      = $clog2(QUEUE_DEPTH + 1);
	localparam int FIFO_DEPTH    = 2;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_QUERY  = 1'b1
	} opcode_t;

	// request transaction
	typedef struct packed {
		opcode_t               opcode;
		logic [ID_BITS-1:0]    requester_id;
		logic [PRI_BITS-1:0]   priority_req;
	} req_t;

	// response transaction
	typedef struct packed {
		logic                  present;
		logic                  dropped;
		logic [ID_BITS-1:0]    head_id;
		logic [PRI_BITS-1:0]   head_priority;
		logic [CNT_BITS-1:0]   entry_count;
	} rsp_t;

	// classified command passed from front to back
	typedef struct packed {
		logic                  is_insert;
		logic [ID_BITS-1:0]    id;
		logic [PRI_BITS-1:0]   pri;
	} cmd_t;

endpackage : spq_pkg
`default_nettype wire

>>> rtl/sorted_priority_queue_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Path from request accept to response valid: the command buffer, then the
// compare and shift insert in the entry row into the response register.
// Throughput: one transaction per cycle while the response does not stall.
// Reset: async active low; clears counts, pointers and response valid only.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top
	import spq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	logic cmd_valid;
	logic cmd_take;
	cmd_t cmd;

	// front end: accept and classify
	spq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd)
	);

	// back end: sorted row and response
	spq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule : sorted_priority_queue_top
`default_nettype wire

>>> rtl/spq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_front
// Accepts request transactions, classifies them and queues the commands
// in a two-entry buffer for the back end.
// ----------------------------------------------------------------------------
module spq_front
	import spq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      cmd_valid,
	input  wire logic cmd_take,
	output cmd_t      cmd
);

	cmd_t                     mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [FIFO_CNT_BITS-1:0] count_q;
	logic                     push;
	logic                     pop;
	cmd_t                     new_cmd;

	// handshake and classification
	assign req_stall = (count_q == FIFO_CNT_BITS'(FIFO_DEPTH));
	assign push      = req_valid && !req_stall;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd       = mem_q[rd_ptr_q];

	always_comb begin
		new_cmd.is_insert = (req.opcode == OP_INSERT);
		new_cmd.id        = req.requester_id;
		new_cmd.pri       = req.priority_req;
	end

	// command storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule : spq_front
`default_nettype wire

>>> rtl/spq_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_back
// Sorted entry row with parallel compare and shift insert, presence
// search, and the response register.
// ----------------------------------------------------------------------------
module spq_back
	import spq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_take,
	input  wire cmd_t cmd,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	logic [ID_BITS-1:0]  ids_q  [QUEUE_DEPTH];
	logic [PRI_BITS-1:0] pris_q [QUEUE_DEPTH];
	logic [CNT_BITS-1:0] fill_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic [QUEUE_DEPTH-1:0] le;
	logic [QUEUE_DEPTH-1:0] ins_here;
	logic [QUEUE_DEPTH-1:0] hit;
	logic [ID_BITS-1:0]     ids_d  [QUEUE_DEPTH];
	logic [PRI_BITS-1:0]    pris_d [QUEUE_DEPTH];
	logic [CNT_BITS-1:0]    fill_d;
	logic                   full;
	logic                   do_ins;
	rsp_t                   rsp_d;

	// take a command when the response slot is free or being emptied
	assign cmd_take  = cmd_valid && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// per-cell compares against the incoming command
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			le[i]  = (CNT_BITS'(i) < fill_q) && (pris_q[i] <= cmd.pri);
			hit[i] = (CNT_BITS'(i) < fill_q) && (ids_q[i] == cmd.id);
		end
		ins_here[0] = !le[0];
		for (int i = 1; i < QUEUE_DEPTH; i++) begin
			ins_here[i] = !le[i] && le[i-1];
		end
	end

	assign full   = (fill_q == CNT_BITS'(QUEUE_DEPTH));
	assign do_ins = cmd.is_insert && !full;
	assign fill_d = do_ins ? fill_q + 1'b1 : fill_q;

	// next contents of the row: keep, insert here, or shift up one
	always_comb begin
		ids_d[0]  = ids_q[0];
		pris_d[0] = pris_q[0];
		if (do_ins && ins_here[0]) begin
			ids_d[0]  = cmd.id;
			pris_d[0] = cmd.pri;
		end
		for (int i = 1; i < QUEUE_DEPTH; i++) begin
			ids_d[i]  = ids_q[i];
			pris_d[i] = pris_q[i];
			if (do_ins && !le[i]) begin
				if (ins_here[i]) begin
					ids_d[i]  = cmd.id;
					pris_d[i] = cmd.pri;
				end else begin
					ids_d[i]  = ids_q[i-1];
					pris_d[i] = pris_q[i-1];
				end
			end
		end
	end

	// response contents
	always_comb begin
		rsp_d.present       = |hit;
		rsp_d.dropped       = cmd.is_insert && full;
		rsp_d.entry_count   = fill_d;
		rsp_d.head_id       = '0;
		rsp_d.head_priority = '0;
		if (fill_d != '0) begin
			rsp_d.head_id       = ids_d[0];
			rsp_d.head_priority = pris_d[0];
		end
	end

	// entry row, no reset: cells at or above the fill count never affect a result
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				ids_q[i]  <= ids_d[i];
				pris_q[i] <= pris_d[i];
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			rsp_q <= rsp_d;
		end
	end

	// fill count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd_take) begin
				fill_q <= fill_d;
			end
			if (cmd_take) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule : spq_back
`default_nettype wire

>>> tb/spq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spq_checker
// Watches the request and response channels of the sorted priority queue.
// Keeps a shadow copy of the ordered entry list. Each accepted request
// yields one predicted response. Accepted responses are compared field by
// field in order.
// ----------------------------------------------------------------------------
module spq_checker
	import spq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	input  wire logic req_stall,
	input  wire req_t req,
	input  wire logic rsp_valid,
	input  wire logic rsp_stall,
	input  wire rsp_t rsp,
	output int        fail_count,
	output int        pending_count
);

	// shadow of the ordered entry list
	logic [ID_BITS-1:0]  shadow_id  [QUEUE_DEPTH];
	logic [PRI_BITS-1:0] shadow_pri [QUEUE_DEPTH];
	int                  shadow_count;

	// predicted responses, oldest first
	rsp_t                predicted_rsp_q [$];
	rsp_t                oldest_rsp;

	initial begin
		fail_count    = 0;
		pending_count = 0;
		shadow_count  = 0;
	end

	// apply one request to the shadow list and return the response it gives
	function automatic rsp_t apply_queue_op(input req_t r);
		rsp_t res;
		int   pos;
		res = '0;
		for (int i = 0; i < shadow_count; i++) begin
			if (shadow_id[i] == r.requester_id)
				res.present = 1'b1;
		end
		if (r.opcode == OP_INSERT) begin
			if (shadow_count >= QUEUE_DEPTH) begin
				res.dropped = 1'b1;
			end else begin
				// stable insert: slide entries of strictly higher priority up
				pos = shadow_count;
				while (pos > 0 && shadow_pri[pos-1] > r.priority_req) begin
					shadow_id[pos]  = shadow_id[pos-1];
					shadow_pri[pos] = shadow_pri[pos-1];
					pos--;
				end
				shadow_id[pos]  = r.requester_id;
				shadow_pri[pos] = r.priority_req;
				shadow_count++;
			end
		end
		if (shadow_count > 0) begin
			res.head_id       = shadow_id[0];
			res.head_priority = shadow_pri[0];
		end
		res.entry_count = CNT_BITS'(shadow_count);
		return res;
	endfunction

	// one field compare with report
	task automatic check_field(input string name, input logic [PRI_BITS-1:0] want,
			input logic [PRI_BITS-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// response check, then request prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_count = 0;
			predicted_rsp_q.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (predicted_rsp_q.size() == 0) begin
					$display("%0t: response with none expected, expected none, actual %h",
						$time, rsp);
					fail_count++;
				end else begin
					oldest_rsp = predicted_rsp_q.pop_front();
					check_field("present", oldest_rsp.present, rsp.present);
					check_field("dropped", oldest_rsp.dropped, rsp.dropped);
					check_field("head_id", oldest_rsp.head_id, rsp.head_id);
					check_field("head_priority", oldest_rsp.head_priority, rsp.head_priority);
					check_field("entry_count", oldest_rsp.entry_count, rsp.entry_count);
				end
			end
			if (req_valid && !req_stall)
				predicted_rsp_q.push_back(apply_queue_op(req));
		end
		pending_count = predicted_rsp_q.size();
	end

endmodule : spq_checker

>>> tb/tb_sorted_priority_queue_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_top
// Drives insert and query transactions into the sorted priority queue with
// random idling on both channels, a long response hold-off and a drain
// pause. The checker beside the block predicts and compares each response.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_top;

	import spq_pkg::*;

	localparam int LONG_HOLD_CYCLES = 400;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	req_t req       = '0;
	logic rsp_stall = 1'b0;
	logic req_stall;
	logic rsp_valid;
	rsp_t rsp;

	int   fail_count;
	int   pending_count;

	bit   req_idle_on   = 1'b1;
	bit   rsp_idle_on   = 1'b1;
	bit   long_hold_req = 1'b0;

	// ids known to be held, used to aim queries and duplicate inserts
	logic [ID_BITS-1:0] held_ids [$];

	sorted_priority_queue_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	spq_checker checker_inst (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp           (rsp),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#3_200_000;
		$display("tb_sorted_priority_queue_top failed");
		$finish;
	end

	// response side stall pattern
	initial begin
		forever begin
			if (long_hold_req) begin
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				long_hold_req = 1'b0;
			end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	// send one transaction, with an optional idle burst ahead of it
	task automatic send_op(input opcode_t op, input logic [ID_BITS-1:0] id,
			input logic [PRI_BITS-1:0] pri);
		int gap;
		gap = 0;
		if (req_idle_on && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 19);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= '{opcode: op, requester_id: id, priority_req: pri};
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		if (op == OP_INSERT && held_ids.size() < QUEUE_DEPTH)
			held_ids.push_back(id);
	endtask

	// priority mix: extremes, small values for ties, and full range
	function automatic logic [PRI_BITS-1:0] pick_priority();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return '1;
			2:       return PRI_BITS'($urandom_range(0, 7));
			default: return PRI_BITS'($urandom);
		endcase
	endfunction

	// id mix: half from the held set when there is one
	function automatic logic [ID_BITS-1:0] pick_id();
		if (held_ids.size() > 0 && $urandom_range(0, 1) == 1)
			return held_ids[$urandom_range(0, held_ids.size() - 1)];
		return ID_BITS'($urandom);
	endfunction

	// random transactions, inserts somewhat less often than queries
	task automatic send_random(input int count);
		opcode_t op;
		for (int n = 0; n < count; n++) begin
			op = ($urandom_range(0, 9) < 4) ? OP_INSERT : OP_QUERY;
			if (op == OP_INSERT)
				send_op(op, pick_id(), pick_priority());
			else
				send_op(op, pick_id(), PRI_BITS'($urandom));
		end
	endtask

	// stimulus and verdict
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue queries
		send_op(OP_QUERY, 8'h00, '0);
		send_op(OP_QUERY, 8'hFF, '1);
		// extremes, new head, duplicate id, equal priority tie
		send_op(OP_INSERT, 8'hA5, '1);
		send_op(OP_INSERT, 8'h00, '0);
		send_op(OP_INSERT, 8'hA5, 32'd100);
		send_op(OP_INSERT, 8'h5A, 32'd100);
		send_op(OP_INSERT, 8'hFF, 32'h8000_0000);
		// queries present and absent, priority ignored
		send_op(OP_QUERY, 8'hFF, '0);
		send_op(OP_QUERY, 8'h01, 32'h5555_5555);
		send_op(OP_QUERY, 8'h5A, '1);
		// fill the rest of the queue
		while (held_ids.size() < QUEUE_DEPTH)
			send_op(OP_INSERT, pick_id(), pick_priority());
		// full queue: dropped inserts and a query
		send_op(OP_INSERT, 8'h01, 32'd3);
		send_op(OP_INSERT, 8'hA5, '0);
		send_op(OP_QUERY, 8'h00, '0);

		// random with idling on both sides
		send_random(600);

		// long response hold-off while requests keep coming
		long_hold_req = 1'b1;
		send_random(60);

		// sender pause until all responses are back
		// step past the last accept first so the checker has counted that request
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		// random with stretches of no idling
		for (int s = 0; s < 6; s++) begin
			req_idle_on = ($urandom_range(0, 3) != 0);
			rsp_idle_on = ($urandom_range(0, 3) != 0);
			send_random(100);
		end

		// last part with no idling at all
		req_idle_on = 1'b0;
		rsp_idle_on = 1'b0;
		send_random(250);

		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0 && pending_count == 0)
			$display("tb_sorted_priority_queue_top passed");
		else
			$display("tb_sorted_priority_queue_top failed");
		$finish;
	end

endmodule : tb_sorted_priority_queue_top

>>> filelist.f
rtl/spq_pkg.sv
rtl/spq_front.sv
rtl/spq_back.sv
rtl/sorted_priority_queue_top.sv
tb/spq_checker.sv
tb/tb_sorted_priority_queue_top.sv
